// File: sv/size_class_bitmap_slot_allocator_assert.svh
// Assertion macros used by the slot allocator back end RTL.
// Simulation builds get checking assertions; synthesis builds get empty bodies.
`ifndef SIZE_CLASS_BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define SCBSA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SCBSA_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCBSA_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCBSA_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// File: sv/scbsa_pkg.sv
// Package for the size-class bitmap slot allocator: constants, status codes,
// and the command record passed from the front end to the back end. No dependencies.
`default_nettype none
package scbsa_pkg;

    localparam int CLASS_SLOTS         = 8;
    localparam int MAP_BITS            = 64;
    localparam int RESET_CLASS         = 3;
    localparam int MAX_SIZE            = 128;
    localparam int QUEUE_DEPTH         = 2;
    localparam int DEF_SLOTS_PER_BATCH = 16;
    localparam int DEF_MAX_BATCHES     = 4;
    localparam int DEF_NUM_CLASSES     = 8;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_ZERO_SIZE   = 3'd1,
        ST_TOO_LARGE   = 3'd2,
        ST_POOL_FULL   = 3'd3,
        ST_DOUBLE_FREE = 3'd4,
        ST_MISALIGNED  = 3'd5,
        ST_OUTSIDE     = 3'd6
    } t_status;

    typedef struct packed {
        logic        is_free;
        t_status     status;
        logic [2:0]  cls;
        logic [12:0] offset;
        logic [12:0] idx;
        logic        misaligned;
    } t_cmd;

endpackage
`default_nettype wire

// File: sv/scbsa_front.sv
// Front end: takes request transfers, rounds sizes to a class, decodes frees.
// Depends on scbsa_pkg.
`default_nettype none
module scbsa_front
    import scbsa_pkg::*;
#(
    parameter int NUM_CLASSES = DEF_NUM_CLASSES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_req_size,
    input  wire logic [2:0]  i_free_class,
    input  wire logic [12:0] i_free_offset,
    output logic             o_cmd_valid,
    input  wire logic        i_cmd_ready,
    output t_cmd             o_cmd
);

    localparam logic [4:0] NC = 5'(NUM_CLASSES);

    logic       r_valid;
    t_cmd       r_cmd;
    t_cmd       n_cmd;
    logic [7:0] size_m1;
    logic [3:0] a_cls;

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        size_m1 = i_req_size - 8'd1;
        a_cls   = '0;
        for (int b = 0; b < 8; b++) begin
            if (size_m1[b]) a_cls = 4'(b + 1);
        end
        n_cmd            = '0;
        n_cmd.is_free    = (i_req_type == REQ_FREE);
        n_cmd.status     = ST_OK;
        n_cmd.offset     = i_free_offset;
        if (i_req_type == REQ_FREE) begin
            n_cmd.cls        = i_free_class;
            n_cmd.idx        = i_free_offset >> i_free_class;
            n_cmd.misaligned = |(i_free_offset & ~(13'h1FFF << i_free_class));
            if ({2'b00, i_free_class} >= NC) n_cmd.status = ST_OUTSIDE;
        end else begin
            priority if (i_req_size == 8'd0) begin
                n_cmd.status = ST_ZERO_SIZE;
            end else if (i_req_size > 8'(MAX_SIZE) || {1'b0, a_cls} >= NC) begin
                n_cmd.status = ST_TOO_LARGE;
            end else begin
                n_cmd.cls = a_cls[2:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule
`default_nettype wire

// File: sv/scbsa_fifo.sv
// Short command queue between front and back ends.
// Depends on scbsa_pkg for the command record.
`default_nettype none
module scbsa_fifo
    import scbsa_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr_valid,
    output logic      o_wr_ready,
    input  wire t_cmd i_wr_data,
    output logic      o_rd_valid,
    input  wire logic i_rd_ready,
    output t_cmd      o_rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          wr_en;
    logic          rd_en;

    assign o_wr_ready = (r_count != CW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule
`default_nettype wire

// File: sv/scbsa_back.sv
// Back end: per-class free bitmaps and batch counts, allocate/free execution,
// result register. Depends on scbsa_pkg and the assertion macro header.
`default_nettype none
`include "size_class_bitmap_slot_allocator_assert.svh"
module scbsa_back
    import scbsa_pkg::*;
#(
    parameter int SLOTS_PER_BATCH = DEF_SLOTS_PER_BATCH,
    parameter int MAX_BATCHES     = DEF_MAX_BATCHES
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cmd_valid,
    output logic        o_cmd_ready,
    input  wire t_cmd   i_cmd,
    output logic        o_valid,
    input  wire logic   i_ready,
    output logic [2:0]  o_status,
    output logic [2:0]  o_slot_class,
    output logic [5:0]  o_slot_num,
    output logic [12:0] o_byte_offset
);

    localparam int FIT   = MAP_BITS / SLOTS_PER_BATCH;
    localparam int LIMIT = (FIT < MAX_BATCHES) ? FIT : MAX_BATCHES;
    localparam int ACT_W = $clog2(LIMIT + 1);
    localparam int NS_W  = $clog2(MAP_BITS + 1);
    localparam int IDX_W = $clog2(MAP_BITS);

    logic [MAP_BITS-1:0] r_map [CLASS_SLOTS];
    logic [ACT_W-1:0]    r_act [CLASS_SLOTS];
    logic                r_o_valid;
    logic [2:0]          r_status;
    logic [2:0]          r_class;
    logic [IDX_W-1:0]    r_index;
    logic [12:0]         r_offset;

    logic                take;
    logic [MAP_BITS-1:0] cur_map;
    logic [ACT_W-1:0]    cur_act;
    logic [NS_W-1:0]     nslots;
    logic [MAP_BITS-1:0] mask;
    logic [MAP_BITS-1:0] avail;
    logic [IDX_W-1:0]    low_idx;
    logic [MAP_BITS-1:0] n_map;
    logic [ACT_W-1:0]    n_act;
    logic                wr;
    t_status             n_status;
    logic [IDX_W-1:0]    n_index;
    logic [12:0]         n_offset;

    assign o_cmd_ready   = !r_o_valid || i_ready;
    assign take          = i_cmd_valid && o_cmd_ready;
    assign o_valid       = r_o_valid;
    assign o_status      = r_status;
    assign o_slot_class  = r_class;
    assign o_slot_num    = 6'(r_index);
    assign o_byte_offset = r_offset;

    always_comb begin
        cur_map = r_map[i_cmd.cls];
        cur_act = r_act[i_cmd.cls];
        nslots  = NS_W'(cur_act * SLOTS_PER_BATCH);
        for (int b = 0; b < MAP_BITS; b++) begin
            mask[b] = (NS_W'(b) < nslots);
        end
        avail   = cur_map & mask;
        low_idx = '0;
        for (int b = MAP_BITS - 1; b >= 0; b--) begin
            if (avail[b]) low_idx = IDX_W'(b);
        end

        n_map    = cur_map;
        n_act    = cur_act;
        wr       = 1'b0;
        n_status = i_cmd.status;
        n_index  = '0;
        n_offset = i_cmd.is_free ? i_cmd.offset : 13'd0;

        if (i_cmd.status == ST_OK) begin
            if (!i_cmd.is_free) begin
                priority if (|avail) begin
                    n_index         = low_idx;
                    n_map[low_idx]  = 1'b0;
                    wr              = 1'b1;
                end else if (cur_act >= ACT_W'(LIMIT)) begin
                    n_status = ST_POOL_FULL;
                end else begin
                    n_index         = nslots[IDX_W-1:0];
                    n_map[n_index]  = 1'b0;
                    n_act           = cur_act + 1'b1;
                    wr              = 1'b1;
                end
                if (n_status == ST_OK) begin
                    n_offset = 13'({{(13 - IDX_W){1'b0}}, n_index} << i_cmd.cls);
                end
            end else begin
                priority if (i_cmd.idx >= 13'(nslots)) begin
                    n_status = ST_OUTSIDE;
                end else if (i_cmd.misaligned) begin
                    n_status = ST_MISALIGNED;
                    n_index  = i_cmd.idx[IDX_W-1:0];
                end else if (cur_map[i_cmd.idx[IDX_W-1:0]]) begin
                    n_status = ST_DOUBLE_FREE;
                    n_index  = i_cmd.idx[IDX_W-1:0];
                end else begin
                    n_index        = i_cmd.idx[IDX_W-1:0];
                    n_map[n_index] = 1'b1;
                    wr             = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            for (int c = 0; c < CLASS_SLOTS; c++) begin
                r_map[c] <= '1;
                r_act[c] <= (c == RESET_CLASS) ? ACT_W'(1) : '0;
            end
        end else begin
            if (o_cmd_ready) begin
                r_o_valid <= i_cmd_valid;
            end
            if (take && wr) begin
                r_map[i_cmd.cls] <= n_map;
                r_act[i_cmd.cls] <= n_act;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_status <= n_status;
            r_class  <= i_cmd.cls;
            r_index  <= n_index;
            r_offset <= n_offset;
        end
    end

    `SCBSA_ASSERT(a_full_at_limit, i_clk, i_rst_n,
        (take && n_status == ST_POOL_FULL) |-> (cur_act == ACT_W'(LIMIT)),
        "pool full below batch limit")
    `SCBSA_ASSERT(a_alloc_was_free, i_clk, i_rst_n,
        (take && !i_cmd.is_free && n_status == ST_OK) |-> cur_map[n_index],
        "allocated slot was busy")
    `SCBSA_ASSERT(a_free_was_busy, i_clk, i_rst_n,
        (take && i_cmd.is_free && n_status == ST_OK) |-> !cur_map[n_index],
        "freed slot was already free")
    `SCBSA_ASSERT(a_take_gives_result, i_clk, i_rst_n,
        take |=> r_o_valid, "accepted command produced no result")
    `SCBSA_ASSERT_RST(a_reset_clears_out, i_clk,
        !i_rst_n |=> !r_o_valid, "result valid after reset")

endmodule
`default_nettype wire

// File: sv/size_class_bitmap_slot_allocator.sv
// Path: a request passes the front register, the queue and the back result
// register before its result is valid; an output stall holds it back further.
// Throughput: one request per cycle while the output is not stalled, bounded
// by the back end's read-modify-write of the class bitmap and batch count.
// Reset: synchronous active low; every bitmap all free, one active batch for the
// eight-byte class, none for the others. Requests are taken the cycle after reset.
`default_nettype none
module size_class_bitmap_slot_allocator
    import scbsa_pkg::*;
#(
    parameter int SLOTS_PER_BATCH = DEF_SLOTS_PER_BATCH,
    parameter int MAX_BATCHES     = DEF_MAX_BATCHES,
    parameter int NUM_CLASSES     = DEF_NUM_CLASSES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_req_size,
    input  wire logic [2:0]  i_free_class,
    input  wire logic [12:0] i_free_offset,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [2:0]       o_slot_class,
    output logic [5:0]       o_slot_num,
    output logic [12:0]      o_byte_offset
);

    logic f_valid;
    logic f_ready;
    t_cmd f_cmd;
    logic q_valid;
    logic q_ready;
    t_cmd q_cmd;

    scbsa_front #(
        .NUM_CLASSES(NUM_CLASSES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_req_size   (i_req_size),
        .i_free_class (i_free_class),
        .i_free_offset(i_free_offset),
        .o_cmd_valid  (f_valid),
        .i_cmd_ready  (f_ready),
        .o_cmd        (f_cmd)
    );

    scbsa_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_valid(f_valid),
        .o_wr_ready(f_ready),
        .i_wr_data (f_cmd),
        .o_rd_valid(q_valid),
        .i_rd_ready(q_ready),
        .o_rd_data (q_cmd)
    );

    scbsa_back #(
        .SLOTS_PER_BATCH(SLOTS_PER_BATCH),
        .MAX_BATCHES    (MAX_BATCHES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_valid),
        .o_cmd_ready  (q_ready),
        .i_cmd        (q_cmd),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_slot_class (o_slot_class),
        .o_slot_num   (o_slot_num),
        .o_byte_offset(o_byte_offset)
    );

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for size_class_bitmap_slot_allocator: directed table, then
// bursts of random alloc/free traffic scored against a per-class bitmap predictor.
// Depends on scbsa_pkg and the allocator RTL.
module tb;
    import scbsa_pkg::*;

    localparam int SLOTS       = DEF_SLOTS_PER_BATCH;
    localparam int BATCH_LIMIT = (MAP_BITS / SLOTS < DEF_MAX_BATCHES) ?
                                 MAP_BITS / SLOTS : DEF_MAX_BATCHES;
    localparam int PHASE_ITEMS = 200;
    localparam int NDIR        = 24;

    typedef struct packed {
        logic        kind;
        logic [7:0]  size;
        logic [2:0]  cls;
        logic [12:0] off;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [2:0]  cls;
        logic [5:0]  idx;
        logic [12:0] off;
    } t_result;

    typedef struct packed {
        t_req    req;
        bit      typed;
        t_result res;
    } t_dir_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        i_req_type    = REQ_ALLOC;
    logic [7:0]  i_req_size    = '0;
    logic [2:0]  i_free_class  = '0;
    logic [12:0] i_free_offset = '0;
    logic        i_ready       = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [2:0]  o_slot_class;
    logic [5:0]  o_slot_num;
    logic [12:0] o_byte_offset;

    bit [63:0] free_bits [CLASS_SLOTS];
    int        batch_cnt [CLASS_SLOTS];
    t_result   pending_results [$];
    t_result   head;
    t_result   no_fixed = '0;
    int        mismatches = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;
    int        phase_sent = 0;

    t_dir_row directed [NDIR] = '{
        '{'{REQ_ALLOC, 8'd0,   3'd7, 13'd8191}, 1'b1, '{ST_ZERO_SIZE,   3'd0, 6'd0, 13'd0}},
        '{'{REQ_ALLOC, 8'd129, 3'd0, 13'd0},    1'b1, '{ST_TOO_LARGE,   3'd0, 6'd0, 13'd0}},
        '{'{REQ_ALLOC, 8'd255, 3'd7, 13'd8191}, 1'b1, '{ST_TOO_LARGE,   3'd0, 6'd0, 13'd0}},
        '{'{REQ_ALLOC, 8'd1,   3'd0, 13'd0},    1'b1, '{ST_OK,          3'd0, 6'd0, 13'd0}},
        '{'{REQ_ALLOC, 8'd8,   3'd5, 13'd4096}, 1'b1, '{ST_OK,          3'd3, 6'd0, 13'd0}},
        '{'{REQ_ALLOC, 8'd128, 3'd0, 13'd0},    1'b1, '{ST_OK,          3'd7, 6'd0, 13'd0}},
        '{'{REQ_ALLOC, 8'd5,   3'd1, 13'd3},    1'b1, '{ST_OK,          3'd3, 6'd1, 13'd8}},
        '{'{REQ_FREE,  8'd255, 3'd3, 13'd8},    1'b1, '{ST_OK,          3'd3, 6'd1, 13'd8}},
        '{'{REQ_FREE,  8'd0,   3'd3, 13'd8},    1'b1, '{ST_DOUBLE_FREE, 3'd3, 6'd1, 13'd8}},
        '{'{REQ_FREE,  8'd0,   3'd3, 13'd12},   1'b1, '{ST_MISALIGNED,  3'd3, 6'd1, 13'd12}},
        '{'{REQ_FREE,  8'd0,   3'd3, 13'd128},  1'b1, '{ST_OUTSIDE,     3'd3, 6'd0, 13'd128}},
        '{'{REQ_FREE,  8'd0,   3'd2, 13'd0},    1'b1, '{ST_OUTSIDE,     3'd2, 6'd0, 13'd0}},
        '{'{REQ_FREE,  8'd255, 3'd7, 13'd8191}, 1'b1, '{ST_OUTSIDE,     3'd7, 6'd0, 13'd8191}},
        '{'{REQ_FREE,  8'd0,   3'd0, 13'd0},    1'b1, '{ST_OK,          3'd0, 6'd0, 13'd0}},
        '{'{REQ_ALLOC, 8'd2,   3'd0, 13'd0},    1'b0, '{ST_OK,          3'd0, 6'd0, 13'd0}},
        '{'{REQ_ALLOC, 8'd3,   3'd0, 13'd0},    1'b0, '{ST_OK,          3'd0, 6'd0, 13'd0}},
        '{'{REQ_ALLOC, 8'd16,  3'd0, 13'd0},    1'b0, '{ST_OK,          3'd0, 6'd0, 13'd0}},
        '{'{REQ_ALLOC, 8'd32,  3'd0, 13'd0},    1'b0, '{ST_OK,          3'd0, 6'd0, 13'd0}},
        '{'{REQ_ALLOC, 8'd64,  3'd0, 13'd0},    1'b0, '{ST_OK,          3'd0, 6'd0, 13'd0}},
        '{'{REQ_ALLOC, 8'd65,  3'd0, 13'd0},    1'b0, '{ST_OK,          3'd0, 6'd0, 13'd0}},
        '{'{REQ_FREE,  8'd0,   3'd7, 13'd128},  1'b0, '{ST_OK,          3'd0, 6'd0, 13'd0}},
        '{'{REQ_FREE,  8'd0,   3'd7, 13'd0},    1'b0, '{ST_OK,          3'd0, 6'd0, 13'd0}},
        '{'{REQ_ALLOC, 8'd9,   3'd0, 13'd0},    1'b0, '{ST_OK,          3'd0, 6'd0, 13'd0}},
        '{'{REQ_FREE,  8'd0,   3'd4, 13'd16},   1'b0, '{ST_OK,          3'd0, 6'd0, 13'd0}}
    };

    size_class_bitmap_slot_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_req_size    (i_req_size),
        .i_free_class  (i_free_class),
        .i_free_offset (i_free_offset),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_slot_class  (o_slot_class),
        .o_slot_num    (o_slot_num),
        .o_byte_offset (o_byte_offset)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit [63:0] active_mask(int c);
        int n;
        n = batch_cnt[c] * SLOTS;
        return (n >= MAP_BITS) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    function automatic t_result apply_request(t_req r);
        t_result   res;
        int        c;
        int        s;
        int        n;
        bit [63:0] avail;
        bit [63:0] old_mask;
        res = '0;
        res.status = ST_OK;
        if (r.kind == REQ_ALLOC) begin
            if (r.size == 0) begin
                res.status = ST_ZERO_SIZE;
            end else if (r.size > MAX_SIZE) begin
                res.status = ST_TOO_LARGE;
            end else begin
                c = 0;
                while ((1 << c) < r.size) c++;
                res.cls = 3'(c);
                avail = free_bits[c] & active_mask(c);
                if (avail != 0) begin
                    s = 0;
                    while (!avail[s]) s++;
                end else if (batch_cnt[c] >= BATCH_LIMIT) begin
                    res.status = ST_POOL_FULL;
                    s = -1;
                end else begin
                    old_mask = active_mask(c);
                    s = batch_cnt[c] * SLOTS;
                    batch_cnt[c]++;
                    free_bits[c] |= active_mask(c) & ~old_mask;
                end
                if (s >= 0) begin
                    free_bits[c][s] = 1'b0;
                    res.idx = 6'(s);
                    res.off = 13'(s << c);
                end
            end
        end else begin
            c = r.cls;
            n = batch_cnt[c] * SLOTS;
            if (n > MAP_BITS) n = MAP_BITS;
            s = r.off >> c;
            res.cls = r.cls;
            res.off = r.off;
            if (s >= n) begin
                res.status = ST_OUTSIDE;
            end else begin
                res.idx = 6'(s);
                if ((r.off & ((13'd1 << c) - 13'd1)) != 0) begin
                    res.status = ST_MISALIGNED;
                end else if (free_bits[c][s]) begin
                    res.status = ST_DOUBLE_FREE;
                end else begin
                    free_bits[c][s] = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic int pick_slot(bit [63:0] mask);
        int start;
        int k;
        start = $urandom_range(0, 63);
        for (k = 0; k < 64; k++) begin
            if (mask[(start + k) % 64]) return (start + k) % 64;
        end
        return -1;
    endfunction

    function automatic t_req make_alloc(int c);
        t_req r;
        r.kind = REQ_ALLOC;
        r.size = (c == 0) ? 8'd1 : 8'($urandom_range((1 << (c - 1)) + 1, 1 << c));
        r.cls  = 3'($urandom_range(0, 7));
        r.off  = 13'($urandom_range(0, 8191));
        return r;
    endfunction

    function automatic t_req make_free(int c);
        t_req      r;
        int        n;
        int        idx;
        int        lo;
        int        mode;
        bit [63:0] live;
        r.kind = REQ_FREE;
        r.size = 8'($urandom_range(0, 255));
        r.cls  = 3'(c);
        n = batch_cnt[c] * SLOTS;
        live = active_mask(c);
        mode = $urandom_range(0, 99);
        idx = -1;
        if (mode < 80 && (~free_bits[c] & live) != 0) begin
            idx = pick_slot(~free_bits[c] & live);
        end else if (mode < 90 && n > 0) begin
            idx = pick_slot(free_bits[c] & live);
        end
        if (idx >= 0) begin
            r.off = 13'(idx << c);
        end else begin
            lo = n << c;
            r.off = (lo <= 8191) ? 13'($urandom_range(lo, 8191))
                                 : 13'($urandom_range(0, 8191));
        end
        if (c > 0 && $urandom_range(0, 99) < 12) begin
            r.off = r.off | 13'($urandom_range(1, (1 << c) - 1));
        end
        return r;
    endfunction

    task automatic send_req(input t_req r, input bit typed, input t_result fixed);
        t_result predicted;
        i_valid       <= 1'b1;
        i_req_type    <= r.kind;
        i_req_size    <= r.size;
        i_free_class  <= r.cls;
        i_free_offset <= r.off;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predicted = apply_request(r);
        pending_results.push_back(typed ? fixed : predicted);
        phase_sent++;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic run_burst(input bit force_fill);
        int   tc;
        int   c;
        int   len;
        int   apct;
        int   k;
        t_req r;
        tc = $urandom_range(0, CLASS_SLOTS - 1);
        if (force_fill || $urandom_range(0, 5) == 0) begin
            while (!(batch_cnt[tc] == BATCH_LIMIT && (free_bits[tc] & active_mask(tc)) == 0))
                send_req(make_alloc(tc), 1'b0, no_fixed);
            repeat (2) send_req(make_alloc(tc), 1'b0, no_fixed);
        end else begin
            len = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0: apct = 85;
                1: apct = 50;
                default: apct = 25;
            endcase
            for (k = 0; k < len; k++) begin
                if ($urandom_range(0, 99) < 10) begin
                    r.kind = 1'($urandom_range(0, 1));
                    r.size = 8'($urandom_range(0, 255));
                    r.cls  = 3'($urandom_range(0, 7));
                    r.off  = 13'($urandom_range(0, 8191));
                end else begin
                    c = ($urandom_range(0, 99) < 70) ? tc : $urandom_range(0, CLASS_SLOTS - 1);
                    r = ($urandom_range(0, 99) < apct) ? make_alloc(c) : make_free(c);
                end
                send_req(r, 1'b0, no_fixed);
            end
        end
    endtask

    task automatic report_mismatch(input string field, input logic [12:0] want,
                                   input logic [12:0] got);
        $display("mismatch %s: expected %0d got %0d at %0t", field, want, got, $time);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transfer, status", 13'd0, 13'(o_status));
            end else begin
                head = pending_results.pop_front();
                if (o_status !== head.status)
                    report_mismatch("status", 13'(head.status), 13'(o_status));
                if (o_slot_class !== head.cls)
                    report_mismatch("slot_class", 13'(head.cls), 13'(o_slot_class));
                if (o_slot_num !== head.idx)
                    report_mismatch("slot_num", 13'(head.idx), 13'(o_slot_num));
                if (o_byte_offset !== head.off)
                    report_mismatch("byte_offset", head.off, o_byte_offset);
            end
        end
    end

    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int ph;
        int k;
        int c;
        for (c = 0; c < CLASS_SLOTS; c++) begin
            free_bits[c] = '1;
            batch_cnt[c] = 0;
        end
        batch_cnt[RESET_CLASS] = 1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 46; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 46; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            phase_sent = 0;
            if (ph == 0) begin
                for (k = 0; k < NDIR; k++)
                    send_req(directed[k].req, directed[k].typed, directed[k].res);
            end
            run_burst(1'b1);
            while (phase_sent < PHASE_ITEMS) run_burst(1'b0);
            // hold off until the pipeline has drained
            i_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
